[rtl/assert_macros.svh]
// Assertion macros shared by the sketch RTL.
// Each macro expects clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define HHDS_ASSERT_NOW(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("sketch assertion failed");

// Condition holds in the cycle after the trigger.
`define HHDS_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("sketch assertion failed");

`endif

[rtl/hhds_pkg.sv]
// Types and constants of the decaying heavy hitter sketch.
// Used by the controller, the datapath and the top level.
package hhds_pkg;

	localparam int ROWS        = 4;
	localparam int BUCKETS_MAX = 1024;
	localparam int ROW_W       = 2;
	localparam int BKT_W       = 10;
	localparam int ADDR_W      = ROW_W + BKT_W;
	localparam int CELLS       = ROWS * BUCKETS_MAX;

	localparam logic [63:0] HH_MIX     = 64'hff51afd7ed558ccd;
	localparam logic [15:0] MIN_RECORD = 16'd2;
	localparam logic [10:0] NB_MAX     = 11'd1024;

	localparam logic OP_TOUCH = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] CFG_BUCKET_COUNT     = 2'd0;
	localparam logic [1:0] CFG_RECORD_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_INV_DECAY_BASE   = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [63:0] key_hash;
		logic [31:0] key_tag;
		logic [15:0] rand_row0;
		logic [15:0] rand_row1;
		logic [15:0] rand_row2;
		logic [15:0] rand_row3;
		logic [1:0]  read_row;
		logic [9:0]  read_bucket;
	} in_t;

	typedef struct packed {
		logic [31:0] cell_count;
		logic [63:0] cell_fingerprint;
		logic [31:0] cell_key_tag;
		logic        tag_valid;
	} out_t;

	typedef struct packed {
		logic        tag_valid;
		logic [31:0] tag;
		logic [31:0] count;
		logic [63:0] fp;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef struct packed {
		logic clr_step;
		logic start;
		logic hash_step;
		logic rd_issue;
		logic decay_init;
		logic decay_step;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_read;
		logic hash_done;
		logic mismatch;
		logic decay_done;
		logic last_row;
		logic out_busy;
	} sts_t;

endpackage

[rtl/hhds_ram.sv]
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module hhds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/hhds_ctrl.sv]
// Sequencer of the sketch: clearing pass, per-row hash, lookup, decay, update and output load.
// Depends on hhds_pkg for the command and status structs.
module hhds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hhds_pkg::sts_t sts,
	output hhds_pkg::cmd_t cmd
);
	import hhds_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_ISSUE, S_EVAL, S_DECAY, S_OUT
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.is_read) begin
					state_d = S_ISSUE;
				end else begin
					cmd.hash_step = 1'b1;
					if (sts.hash_done) state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				if (sts.is_read) begin
					state_d = S_OUT;
				end else if (sts.mismatch) begin
					cmd.decay_init = 1'b1;
					state_d        = S_DECAY;
				end else begin
					cmd.commit = 1'b1;
					state_d    = sts.last_row ? S_OUT : S_HASH;
				end
			end
			S_DECAY: begin
				if (sts.decay_done) begin
					cmd.commit = 1'b1;
					state_d    = sts.last_row ? S_OUT : S_HASH;
				end else begin
					cmd.decay_step = 1'b1;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[rtl/hhds_dp.sv]
// Datapath of the sketch: configuration, bit-serial modulo and multiply,
// decay threshold iteration, cell update and the output register. Uses hhds_pkg.
`include "assert_macros.svh"
module hhds_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hhds_pkg::in_t               in_data,
	output hhds_pkg::out_t              out_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data,
	input  hhds_pkg::cmd_t              cmd,
	output hhds_pkg::sts_t              sts,
	output logic                        ram_we,
	output logic [hhds_pkg::ADDR_W-1:0] ram_waddr,
	output logic [hhds_pkg::CELL_W-1:0] ram_wdata,
	output logic                        ram_re,
	output logic [hhds_pkg::ADDR_W-1:0] ram_raddr,
	input  logic [hhds_pkg::CELL_W-1:0] ram_rdata
);
	import hhds_pkg::*;

	logic [10:0]       bucket_count_q;
	logic [15:0]       record_threshold_q;
	logic [15:0]       inv_decay_base_q;
	logic [10:0]       nb;
	logic [15:0]       thr;

	in_t               req_q;
	logic [63:0]       h_q;
	logic [63:0]       prod_q;
	logic [10:0]       rem_q;
	logic [5:0]        step_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] clr_q;
	logic [16:0]       t_q;
	logic [31:0]       iter_q;
	logic              have_q;
	logic [31:0]       best_q;
	logic [31:0]       best_tag_q;
	logic              best_valid_q;
	out_t              out_q;
	logic              out_valid_q;

	logic [11:0]       rem_sh;
	logic [11:0]       rem_sub;
	logic [63:0]       prod_add;
	logic [32:0]       t_prod;
	logic [15:0]       rnd;
	cell_t             cur;
	cell_t             upd;
	logic [31:0]       cnt_inc;
	logic              decays;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (bucket_count_q == 11'd0) nb = 11'd1;
		else if (bucket_count_q > NB_MAX) nb = NB_MAX;
		else nb = bucket_count_q;
		thr = (record_threshold_q < MIN_RECORD) ? MIN_RECORD : record_threshold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q     <= 11'd1024;
			record_threshold_q <= 16'd2;
			inv_decay_base_q   <= 16'd60681;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BUCKET_COUNT:     bucket_count_q     <= cfg_data[10:0];
				CFG_RECORD_THRESHOLD: record_threshold_q <= cfg_data;
				CFG_INV_DECAY_BASE:   inv_decay_base_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// One quotient bit of h mod nb and one partial product of h * mix per step.
	always_comb begin
		rem_sh   = {rem_q, h_q[~step_q]};
		rem_sub  = rem_sh - {1'b0, nb};
		prod_add = prod_q + (h_q[step_q] ? (HH_MIX << step_q) : 64'd0);
	end

	always_comb begin
		case (row_q)
			2'd0: rnd = req_q.rand_row0;
			2'd1: rnd = req_q.rand_row1;
			2'd2: rnd = req_q.rand_row2;
			default: rnd = req_q.rand_row3;
		endcase
		t_prod = t_q * {1'b0, inv_decay_base_q};
	end

	assign cur     = cell_t'(ram_rdata);
	assign cnt_inc = (cur.count == 32'hFFFF_FFFF) ? cur.count : cur.count + 32'd1;
	assign decays  = ({1'b0, rnd} < t_q);

	always_comb begin
		upd = cur;
		if (cur.count == 32'd0) begin
			upd = '{tag_valid: 1'b0, tag: 32'd0, count: 32'd1, fp: prod_q};
		end else if (cur.fp == prod_q) begin
			upd.count = cnt_inc;
			if (cnt_inc >= {16'd0, thr} && !cur.tag_valid) begin
				upd.tag       = req_q.key_tag;
				upd.tag_valid = 1'b1;
			end
		end else if (decays) begin
			if (cur.count == 32'd1) begin
				upd = '{tag_valid: 1'b0, tag: 32'd0, count: 32'd1, fp: prod_q};
			end else begin
				upd.count = cur.count - 32'd1;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_done   = (clr_q == {ADDR_W{1'b1}});
		sts.is_read    = (req_q.operation == OP_READ);
		sts.hash_done  = (step_q == 6'd63);
		sts.mismatch   = (cur.count != 32'd0) && (cur.fp != prod_q);
		sts.decay_done = (t_q <= {1'b0, rnd}) || (iter_q == cur.count);
		sts.last_row   = (row_q == ROW_W'(ROWS - 1));
		sts.out_busy   = out_valid_q && out_stall;
	end

	always_comb begin
		ram_we    = cmd.clr_step || cmd.commit;
		ram_waddr = cmd.clr_step ? clr_q : {row_q, rem_q[BKT_W-1:0]};
		ram_wdata = cmd.clr_step ? '0 : CELL_W'(upd);
		ram_re    = cmd.rd_issue;
		ram_raddr = sts.is_read ? {req_q.read_row, req_q.read_bucket}
		                        : {row_q, rem_q[BKT_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q  <= in_data;
			h_q    <= in_data.key_hash;
			prod_q <= '0;
			rem_q  <= '0;
			step_q <= '0;
			row_q  <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			best_tag_q   <= '0;
			best_valid_q <= 1'b0;
		end
		if (cmd.hash_step) begin
			rem_q  <= (rem_sh >= {1'b0, nb}) ? rem_sub[10:0] : rem_sh[10:0];
			prod_q <= prod_add;
			step_q <= step_q + 6'd1;
		end
		if (cmd.decay_init) begin
			t_q    <= 17'h10000;
			iter_q <= '0;
		end
		if (cmd.decay_step) begin
			t_q    <= t_prod[32:16];
			iter_q <= iter_q + 32'd1;
		end
		if (cmd.commit) begin
			h_q    <= prod_q;
			prod_q <= '0;
			rem_q  <= '0;
			step_q <= '0;
			row_q  <= row_q + 1'b1;
			if (upd.fp == prod_q && upd.count != 32'd0 && (!have_q || upd.count > best_q)) begin
				have_q       <= 1'b1;
				best_q       <= upd.count;
				best_valid_q <= upd.tag_valid;
				best_tag_q   <= upd.tag_valid ? upd.tag : 32'd0;
			end
		end
		if (cmd.out_load) begin
			if (sts.is_read) begin
				out_q.cell_count       <= cur.count;
				out_q.cell_fingerprint <= cur.fp;
				out_q.cell_key_tag     <= cur.tag_valid ? cur.tag : 32'd0;
				out_q.tag_valid        <= cur.tag_valid;
			end else begin
				out_q.cell_count       <= best_q;
				out_q.cell_fingerprint <= '0;
				out_q.cell_key_tag     <= best_tag_q;
				out_q.tag_valid        <= best_valid_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`HHDS_ASSERT_NEXT(a_rem_below_nb, cmd.hash_step, rem_q < nb)
	`HHDS_ASSERT_NEXT(a_decay_monotone, cmd.decay_step, t_q <= $past(t_q))
	`HHDS_ASSERT_NOW(a_load_only_free, cmd.out_load, !(out_valid_q && out_stall))
endmodule

[rtl/heavy_hitter_decay_sketch.sv]
// Decaying heavy hitter sketch: 4 rows of 1024 cells, fingerprint, count and tag.
// A read goes from the taken request straight to the lookup (read issue, evaluate) and then
// loads the result. A touch runs per row the bit-serial modulo and multiply, the lookup, on a
// mismatch the decay iteration, and the write back of the cell, then loads the result after the last row.
// One request at a time: the next is taken once the result is loaded; a stalled result
// holds the block. After reset a clearing pass writes zeros to all 4096 cells first.
module heavy_hitter_decay_sketch (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  hhds_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output hhds_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import hhds_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;

	hhds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hhds_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	hhds_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule
